// ----- rtl/cwma_pkg.sv -----
// ----------------------------------------------------------------------------
// cwma_pkg
// Shared types and constants for the centered weighted moving average block.
// ----------------------------------------------------------------------------
package cwma_pkg;

    localparam int WEIGHT_BITS   = 18;
    localparam int FRAC_BITS     = 16;
    localparam int WEIGHT_COUNT  = 7;
    localparam int CNT_BITS      = 3;
    localparam int TAP_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 18;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT_0  = 3'd1;

    localparam logic [TAP_BITS-1:0]           TAP_RESET    = 3'd7;
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_RESET = 18'sd9362;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

    typedef struct packed {
        logic                valid;
        logic [CNT_BITS-1:0] reps;
        logic                last;
        logic                short_set;
    } ctrl_t;

endpackage

// ----- rtl/cwma_cell.sv -----
// ----------------------------------------------------------------------------
// cwma_cell
// One window tap: holds one delayed sample, passes it to the next cell and
// registers the sample times its weight.
// ----------------------------------------------------------------------------
module cwma_cell
    import cwma_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   shift_en,
    input  logic                                   pipe_en,
    input  logic                                   tap_on,
    input  logic signed [SAMPLE_BITS-1:0]          sample_in,
    input  weight_t                                weight,
    output logic signed [SAMPLE_BITS-1:0]          sample_out,
    output logic signed [SAMPLE_BITS+WEIGHT_BITS-1:0] product
);

    logic signed [SAMPLE_BITS-1:0]             hold_reg;
    logic signed [SAMPLE_BITS+WEIGHT_BITS-1:0] product_reg;
    logic signed [SAMPLE_BITS+WEIGHT_BITS-1:0] product_next;

    always_comb
    begin
        product_next = '0;
        if (tap_on)
        begin
            product_next = sample_in * weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else if (shift_en)
        begin
            hold_reg <= sample_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            product_reg <= product_next;
        end
    end

    assign sample_out = hold_reg;
    assign product    = product_reg;

endmodule

// ----- rtl/cwma_sum.sv -----
// ----------------------------------------------------------------------------
// cwma_sum
// Registered adder tree over the cell products, then round half up and
// saturate to the sample range. Control rides alongside the data.
// ----------------------------------------------------------------------------
module cwma_sum
    import cwma_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_TAPS    = 7,
    localparam int PROD_W     = SAMPLE_BITS + WEIGHT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [PROD_W-1:0]      product [MAX_TAPS],
    input  ctrl_t                         ctrl_in,
    output logic signed [SAMPLE_BITS-1:0] result,
    output logic                          sat,
    output ctrl_t                         ctrl_out
);

    localparam int NP     = (MAX_TAPS + 1) / 2;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PAIR_W-1:0] pair_next [NP];
    logic signed [PAIR_W-1:0] pair_reg  [NP];
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;
    ctrl_t                    ctrl1_reg;
    ctrl_t                    ctrl2_reg;
    ctrl_t                    ctrl3_reg;

    for (genvar j = 0; j < NP; j++)
    begin : g_pair
        if (2 * j + 1 < MAX_TAPS)
        begin : g_two
            assign pair_next[j] = PAIR_W'(product[2*j]) + PAIR_W'(product[2*j+1]);
        end
        else
        begin : g_one
            assign pair_next[j] = PAIR_W'(product[2*j]);
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int j = 0; j < NP; j++)
        begin
            acc_next = acc_next + ACC_W'(pair_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg <= pair_next;
            acc_reg  <= acc_next;
        end
    end

    // control follows products, pair sums and full sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else if (en)
        begin
            ctrl1_reg <= ctrl_in;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    // round half up, floor shift
    assign rnd     = acc_reg + ROUND_HALF;
    assign shifted = rnd >>> FRAC_BITS;

    always_comb
    begin
        result = shifted[SAMPLE_BITS-1:0];
        sat    = 1'b0;
        if (shifted > SAT_HI)
        begin
            result = SAT_HI[SAMPLE_BITS-1:0];
            sat    = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            result = SAT_LO[SAMPLE_BITS-1:0];
            sat    = 1'b1;
        end
    end

    assign ctrl_out = ctrl3_reg;

endmodule

// ----- rtl/cwma_emit.sv -----
// ----------------------------------------------------------------------------
// cwma_emit
// Output register: sends each result word as many times as its control asks,
// flagging the final repeat.
// ----------------------------------------------------------------------------
module cwma_emit
    import cwma_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_t                         ctrl,
    input  logic signed [SAMPLE_BITS-1:0] value,
    input  logic                          sat,
    output logic                          can_load,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          run_last,
    output logic                          set_last,
    output logic                          short_set,
    output logic                          saturated
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [CNT_BITS-1:0]           left_reg;
    logic [CNT_BITS-1:0]           left_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          sat_reg;
    logic                          short_reg;
    logic                          last_reg;
    logic                          last_word;
    logic                          take;

    assign last_word = (left_reg == CNT_BITS'(1));
    assign can_load  = !valid_reg || (out_ready && last_word);
    assign take      = can_load && ctrl.valid && (ctrl.reps != '0);

    always_comb
    begin
        valid_next = valid_reg;
        left_next  = left_reg;
        if (take)
        begin
            valid_next = 1'b1;
            left_next  = ctrl.reps;
        end
        else if (valid_reg && out_ready)
        begin
            if (last_word)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                left_next = left_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= ctrl.short_set ? '0 : value;
            sat_reg   <= ctrl.short_set ? 1'b0 : sat;
            short_reg <= ctrl.short_set;
            last_reg  <= ctrl.last;
        end
    end

    assign out_valid = valid_reg;
    assign smoothed  = value_reg;
    assign run_last  = last_word;
    assign set_last  = last_word && last_reg;
    assign short_set = short_reg;
    assign saturated = sat_reg;

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> left_reg != '0)
        else $error("word pending with no repeats left");

    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !can_load |-> valid_reg)
        else $error("pipeline held with empty output register");

endmodule

// ----- rtl/centered_weighted_moving_average_top.sv -----
// ----------------------------------------------------------------------------
// centered_weighted_moving_average_top
// Centered weighted moving average: a chain of tap cells feeding a registered
// adder tree, round/saturate, and a repeating output register.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  cfg      | cfg_write, cfg_index, cfg_data            | in
//  in       | in_valid/in_ready: sample, end_of_input   | in
//  out      | out_valid/out_ready: smoothed, run_last,  | out
//           |   set_last, short_set, saturated          |
//
//  One input word per cycle while the output register can load; each word
//  passes the cell product, pair sum, full sum and output registers in turn.
//  A word that opens the first full window, or ends the set, is sent (taps-1)/2
//  extra times and holds the input while its repeats drain from the output
//  register, taps-1 extra times when it does both; the last word of a short set
//  of n words is sent n times and holds the input while they drain.
//  Reset clears the sample line, the set counter and the pipeline control, and
//  loads the registers (tap_count 7, weights 9362). A stalled output stalls the pipeline.
// ----------------------------------------------------------------------------
module centered_weighted_moving_average_top
    import cwma_pkg::*;
#(
    parameter int MAX_TAPS    = 7,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          end_of_input,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          run_last,
    output logic                          set_last,
    output logic                          short_set,
    output logic                          saturated
);

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;

    logic [TAP_BITS-1:0]           tap_reg;
    weight_t                       weight_reg [WEIGHT_COUNT];
    logic [CNT_BITS-1:0]           seen_reg;
    logic [CNT_BITS-1:0]           seen_next;

    logic [TAP_BITS-1:0]           t_cap;
    logic [TAP_BITS-1:0]           taps;
    logic [TAP_BITS-1:0]           half;
    logic [CNT_BITS:0]             n;
    logic                          full;
    logic                          accept;
    logic                          advance;
    ctrl_t                         ctrl_in;
    ctrl_t                         ctrl_out;

    logic signed [SAMPLE_BITS-1:0] line_out [MAX_TAPS];
    logic signed [PROD_W-1:0]      product  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] result;
    logic                          sat;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= TAP_RESET;
            for (int i = 0; i < WEIGHT_COUNT; i++)
            begin
                weight_reg[i] <= WEIGHT_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TAP_COUNT:
                begin
                    tap_reg <= cfg_data[TAP_BITS-1:0];
                end
                default:
                begin
                    weight_reg[cfg_index - CFG_WEIGHT_0] <= cfg_data;
                end
            endcase
        end
    end

    // window length in use: capped, forced odd, zero acts as one
    always_comb
    begin
        t_cap = (tap_reg > TAP_BITS'(MAX_TAPS)) ? TAP_BITS'(MAX_TAPS) : tap_reg;
        if (t_cap[0])
        begin
            taps = t_cap;
        end
        else if (t_cap == '0)
        begin
            taps = TAP_BITS'(1);
        end
        else
        begin
            taps = t_cap - TAP_BITS'(1);
        end
        half = (taps - TAP_BITS'(1)) >> 1;
    end

    assign advance  = in_ready;
    assign accept   = in_valid && in_ready;
    assign n        = {1'b0, seen_reg} + (CNT_BITS+1)'(1);
    assign full     = (n >= {1'b0, taps});

    always_comb
    begin
        ctrl_in.valid     = accept;
        ctrl_in.last      = end_of_input;
        ctrl_in.short_set = !full;
        ctrl_in.reps      = '0;
        if (full)
        begin
            ctrl_in.reps = (n == {1'b0, taps}) ? half + CNT_BITS'(1) : CNT_BITS'(1);
            if (end_of_input)
            begin
                ctrl_in.reps = ctrl_in.reps + half;
            end
        end
        else if (end_of_input)
        begin
            ctrl_in.reps = n[CNT_BITS-1:0];
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (end_of_input)
            begin
                seen_next = '0;
            end
            else if (n[CNT_BITS])
            begin
                seen_next = '1;
            end
            else
            begin
                seen_next = n[CNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // cell k sees the k-th newest sample and takes weight taps-1-k
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        logic                          tap_on;
        logic [TAP_BITS-1:0]           widx;
        weight_t                       cell_weight;
        logic signed [SAMPLE_BITS-1:0] cell_in;

        assign tap_on      = (TAP_BITS'(k) < taps);
        assign widx        = taps - TAP_BITS'(k + 1);
        assign cell_weight = tap_on ? weight_reg[widx] : '0;

        if (k == 0)
        begin : g_head
            assign cell_in = sample;
        end
        else
        begin : g_link
            assign cell_in = line_out[k-1];
        end

        cwma_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (accept),
            .pipe_en    (advance),
            .tap_on     (tap_on),
            .sample_in  (cell_in),
            .weight     (cell_weight),
            .sample_out (line_out[k]),
            .product    (product[k])
        );
    end

    cwma_sum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .product  (product),
        .ctrl_in  (ctrl_in),
        .result   (result),
        .sat      (sat),
        .ctrl_out (ctrl_out)
    );

    cwma_emit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_out),
        .value     (result),
        .sat       (sat),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .smoothed  (smoothed),
        .run_last  (run_last),
        .set_last  (set_last),
        .short_set (short_set),
        .saturated (saturated)
    );

    a_set_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> seen_reg == '0)
        else $error("set counter not cleared after last word");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && short_set) |-> (smoothed == '0 && !saturated))
        else $error("short set word carries data");

endmodule
